// ===== rtl/ptsn_pkg.sv =====
package ptsn_pkg;

  localparam int PITCH_W     = 22;
  localparam int REF_W       = 17;
  localparam int FRAC_BITS   = 8;
  localparam int LOG_FRAC    = 24;
  localparam int LOG_INT_W   = 5;
  localparam int LOG_W       = LOG_INT_W + LOG_FRAC;
  localparam int MANT_W      = 32;
  localparam int NOTE_W      = 10;
  localparam int Q_W         = 6;
  localparam int RATIO_W     = 25;
  localparam int PROD_W      = REF_W + RATIO_W;
  localparam int HP_W        = 49;
  localparam int OUT_W       = 23;
  localparam int SEMI_W      = 8;
  localparam int CLASS_W     = 4;
  localparam int DIV_X_W     = 9;

  localparam logic [REF_W-1:0] REF_RESET = 17'd112640;
  localparam logic [OUT_W-1:0] PITCH_MAX = 23'd8388607;
  localparam logic [9:0]       RECIP_12  = 10'd683;

  typedef struct packed {
    logic [MANT_W-1:0] m;
    logic              b;
  } log_step_t;

  typedef enum logic [1:0] {
    REF_IDLE,
    REF_LOAD,
    REF_CALC
  } ref_state_t;

  function automatic logic [LOG_INT_W-1:0] lead_one(input logic [MANT_W-1:0] v);
    logic [LOG_INT_W-1:0] e;
    e = '0;
    for (int i = 0; i < MANT_W; i++) begin
      if (v[i]) e = LOG_INT_W'(i);
    end
    return e;
  endfunction

  function automatic logic [MANT_W-1:0] norm_mant(input logic [MANT_W-1:0] v,
                                                  input logic [LOG_INT_W-1:0] e);
    return v << (LOG_INT_W'(MANT_W - 1) - e);
  endfunction

  // one fraction bit of log2: square the mantissa, renormalize
  function automatic log_step_t log_step(input logic [MANT_W-1:0] m);
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     s;
    log_step_t           r;
    sq = m * m;
    s  = sq[2*MANT_W-1:MANT_W-1];
    if (s[MANT_W]) begin
      r.m = s[MANT_W:1];
      r.b = 1'b1;
    end else begin
      r.m = s[MANT_W-1:0];
      r.b = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [RATIO_W-1:0] semitone_ratio(input logic [CLASS_W-1:0] k);
    logic [RATIO_W-1:0] r;
    case (k)
      4'd0:    r = 25'd16777216;
      4'd1:    r = 25'd17774841;
      4'd2:    r = 25'd18831788;
      4'd3:    r = 25'd19951585;
      4'd4:    r = 25'd21137968;
      4'd5:    r = 25'd22394897;
      4'd6:    r = 25'd23726566;
      4'd7:    r = 25'd25137421;
      4'd8:    r = 25'd26632170;
      4'd9:    r = 25'd28215802;
      4'd10:   r = 25'd29893600;
      4'd11:   r = 25'd31671166;
      default: r = 25'd16777216;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/ptsn_ref_log.sv =====
module ptsn_ref_log (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ptsn_pkg::REF_W-1:0]    reference_pitch_q8,
  output logic                          busy,
  output logic [ptsn_pkg::REF_W-1:0]    ref_val,
  output logic [ptsn_pkg::LOG_W-1:0]    ref_log
);

  ptsn_pkg::ref_state_t state, state_next;
  logic [ptsn_pkg::MANT_W-1:0]    m;
  logic [ptsn_pkg::LOG_INT_W-1:0] e;
  logic [ptsn_pkg::LOG_FRAC-1:0]  frac;
  logic [ptsn_pkg::LOG_INT_W-1:0] cnt;
  logic [ptsn_pkg::MANT_W-1:0]    ref_ext;
  logic [ptsn_pkg::LOG_INT_W-1:0] ref_e;
  ptsn_pkg::log_step_t            st;

  assign ref_ext = ptsn_pkg::MANT_W'(ref_val);
  assign ref_e   = ptsn_pkg::lead_one(ref_ext);
  assign st      = ptsn_pkg::log_step(m);

  always_comb begin
    state_next = state;
    case (state)
      ptsn_pkg::REF_IDLE: if (cfg_valid) state_next = ptsn_pkg::REF_LOAD;
      ptsn_pkg::REF_LOAD: state_next = ptsn_pkg::REF_CALC;
      ptsn_pkg::REF_CALC: if (cnt == '0) state_next = ptsn_pkg::REF_IDLE;
      default:            state_next = ptsn_pkg::REF_IDLE;
    endcase
  end

  always_comb begin
    cfg_ready = (state == ptsn_pkg::REF_IDLE);
    busy      = (state != ptsn_pkg::REF_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ptsn_pkg::REF_LOAD;
      ref_val <= ptsn_pkg::REF_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        ref_val <= (reference_pitch_q8 == '0) ? ptsn_pkg::REF_W'(1) : reference_pitch_q8;
      end
    end
    case (state)
      ptsn_pkg::REF_LOAD: begin
        m    <= ptsn_pkg::norm_mant(ref_ext, ref_e);
        e    <= ref_e;
        frac <= '0;
        cnt  <= ptsn_pkg::LOG_INT_W'(ptsn_pkg::LOG_FRAC - 1);
      end
      ptsn_pkg::REF_CALC: begin
        m         <= st.m;
        frac[cnt] <= st.b;
        cnt       <= cnt - 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign ref_log = {e, frac};

endmodule

// ===== rtl/ptsn_log_pipe.sv =====
module ptsn_log_pipe (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ptsn_pkg::PITCH_W-1:0]  pitch_q8,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_no_pitch,
  output logic [ptsn_pkg::LOG_W-1:0]    out_log
);

  localparam int N = ptsn_pkg::LOG_FRAC;

  logic [N:0]                     v;
  logic [N+1:0]                   rdy;
  logic [ptsn_pkg::MANT_W-1:0]    m    [0:N];
  logic [ptsn_pkg::LOG_INT_W-1:0] e    [0:N];
  logic [ptsn_pkg::LOG_FRAC-1:0]  frac [0:N];
  logic                           np   [0:N];
  logic [ptsn_pkg::MANT_W-1:0]    p_ext;
  logic [ptsn_pkg::LOG_INT_W-1:0] p_e;

  always_comb begin
    rdy[N+1] = out_ready;
    for (int i = N; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign in_ready = rdy[0];
  assign p_ext    = ptsn_pkg::MANT_W'(pitch_q8);
  assign p_e      = ptsn_pkg::lead_one(p_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (rdy[0]) begin
      v[0] <= in_valid;
    end
    if (rdy[0]) begin
      m[0]    <= ptsn_pkg::norm_mant(p_ext, p_e);
      e[0]    <= p_e;
      frac[0] <= '0;
      np[0]   <= (pitch_q8[ptsn_pkg::PITCH_W-1:ptsn_pkg::FRAC_BITS] == '0);
    end
  end

  for (genvar i = 1; i <= N; i++) begin : g_step
    ptsn_pkg::log_step_t st;
    assign st = ptsn_pkg::log_step(m[i-1]);
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (rdy[i]) begin
        v[i] <= v[i-1];
      end
      if (rdy[i]) begin
        m[i]    <= st.m;
        e[i]    <= e[i-1];
        np[i]   <= np[i-1];
        frac[i] <= frac[i-1] | ({{(N-1){1'b0}}, st.b} << (N - i));
      end
    end
  end

  assign out_valid    = v[N];
  assign out_no_pitch = np[N];
  assign out_log      = {e[N], frac[N]};

endmodule

// ===== rtl/ptsn_note_pipe.sv =====
module ptsn_note_pipe (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_no_pitch,
  input  logic [ptsn_pkg::LOG_W-1:0]          pitch_log,
  input  logic [ptsn_pkg::LOG_W-1:0]          ref_log,
  input  logic [ptsn_pkg::REF_W-1:0]          ref_val,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                no_pitch,
  output logic signed [ptsn_pkg::SEMI_W-1:0]  semitone_number,
  output logic [ptsn_pkg::CLASS_W-1:0]        note_class,
  output logic [ptsn_pkg::OUT_W-1:0]          center_pitch_q8,
  output logic [ptsn_pkg::OUT_W-1:0]          low_edge_q8,
  output logic [ptsn_pkg::OUT_W-1:0]          high_edge_q8
);

  localparam int NS  = 6;
  localparam int DW  = ptsn_pkg::LOG_W + 1;
  localparam int TW  = DW + 4;
  localparam int NW  = ptsn_pkg::NOTE_W;
  localparam int QW  = ptsn_pkg::Q_W;
  localparam int KW  = ptsn_pkg::CLASS_W;
  localparam int XW  = ptsn_pkg::DIV_X_W;
  localparam int PW  = ptsn_pkg::PROD_W;
  localparam int HW  = ptsn_pkg::HP_W;
  localparam int SW  = HW + 1;

  logic [NS-1:0] v;
  logic [NS:0]   rdy;
  logic          np [0:NS-2];

  always_comb begin
    rdy[NS] = out_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) v[i] <= v[i-1];
      end
    end
    if (rdy[0]) np[0] <= in_no_pitch;
    for (int i = 1; i < NS - 1; i++) begin
      if (rdy[i]) np[i] <= np[i-1];
    end
  end

  // stage A: 12 * (log2 pitch - log2 ref)
  logic signed [DW-1:0] d;
  logic signed [TW-1:0] d_ext, t_a;
  assign d     = $signed({1'b0, pitch_log}) - $signed({1'b0, ref_log});
  assign d_ext = TW'(d);

  always_ff @(posedge clk) begin
    if (rdy[0]) t_a <= (d_ext <<< 3) + (d_ext <<< 2);
  end

  // stage B: round half away from zero
  logic [TW-1:0]        mag, mag_r;
  logic signed [NW-1:0] n_b;
  assign mag   = t_a[TW-1] ? TW'(-t_a) : TW'(t_a);
  assign mag_r = mag + (TW'(1) << (ptsn_pkg::LOG_FRAC - 1));

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      n_b <= t_a[TW-1] ? -$signed(mag_r[ptsn_pkg::LOG_FRAC +: NW])
                       : $signed(mag_r[ptsn_pkg::LOG_FRAC +: NW]);
    end
  end

  // stage C: floor divide by 12 for n-1, n, n+1
  logic signed [QW-1:0]        q_c [0:2];
  logic [KW-1:0]               k_c [0:2];
  logic signed [ptsn_pkg::SEMI_W-1:0] semi_c;

  for (genvar j = 0; j < 3; j++) begin : g_div
    logic [NW-1:0] x_full;
    logic [XW-1:0] x;
    logic [XW+9:0] pr;
    logic [QW-1:0] qp;
    logic [XW-1:0] rem;
    assign x_full = NW'(n_b) + NW'(119 + j);
    assign x      = x_full[XW-1:0];
    assign pr     = x * ptsn_pkg::RECIP_12;
    assign qp     = pr[XW+9:13];
    assign rem    = x - XW'(qp) * XW'(12);
    always_ff @(posedge clk) begin
      if (rdy[2]) begin
        q_c[j] <= $signed(qp) - QW'(10);
        k_c[j] <= rem[KW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      if (n_b > NW'(127))        semi_c <= 8'sd127;
      else if (n_b < -NW'(128))  semi_c <= -8'sd128;
      else                       semi_c <= n_b[ptsn_pkg::SEMI_W-1:0];
    end
  end

  // stage D: ref * 2^(k/12)
  logic [PW-1:0]               prod_d [0:2];
  logic signed [QW-1:0]        q_d    [0:2];
  logic signed [ptsn_pkg::SEMI_W-1:0] semi_d;
  logic [KW-1:0]               cls_d;

  for (genvar j = 0; j < 3; j++) begin : g_mul
    always_ff @(posedge clk) begin
      if (rdy[3]) begin
        prod_d[j] <= PW'(ref_val) * PW'(ptsn_pkg::semitone_ratio(k_c[j]));
        q_d[j]    <= q_c[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      semi_d <= semi_c;
      cls_d  <= k_c[1];
    end
  end

  // stage E: scale by 2^q, keeping 16 fraction bits
  logic [HW-1:0]               hp_e [0:2];
  logic signed [ptsn_pkg::SEMI_W-1:0] semi_e;
  logic [KW-1:0]               cls_e;

  for (genvar j = 0; j < 3; j++) begin : g_shift
    logic [HW-1:0] pw;
    logic [QW-1:0] shr, shl;
    assign pw  = HW'(prod_d[j]);
    assign shr = QW'(16) - q_d[j];
    assign shl = q_d[j] - QW'(16);
    always_ff @(posedge clk) begin
      if (rdy[4]) hp_e[j] <= (q_d[j] <= QW'(16)) ? (pw >> shr) : (pw << shl);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      semi_e <= semi_d;
      cls_e  <= cls_d;
    end
  end

  // stage F: round, average for edges, saturate, zero on no pitch, output register
  logic [SW-1:0] c_sum, l_sum, h_sum;
  logic [SW-1:0] c_q, l_q, h_q;
  assign c_sum = SW'(hp_e[1]) + SW'(128);
  assign l_sum = SW'(hp_e[0]) + SW'(hp_e[1]) + SW'(256);
  assign h_sum = SW'(hp_e[1]) + SW'(hp_e[2]) + SW'(256);
  assign c_q   = c_sum >> 8;
  assign l_q   = l_sum >> 9;
  assign h_q   = h_sum >> 9;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      no_pitch <= np[4];
      if (np[4]) begin
        semitone_number <= '0;
        note_class      <= '0;
        center_pitch_q8 <= '0;
        low_edge_q8     <= '0;
        high_edge_q8    <= '0;
      end else begin
        semitone_number <= semi_e;
        note_class      <= cls_e;
        center_pitch_q8 <= (c_q > SW'(ptsn_pkg::PITCH_MAX)) ? ptsn_pkg::PITCH_MAX
                                                            : c_q[ptsn_pkg::OUT_W-1:0];
        low_edge_q8     <= (l_q > SW'(ptsn_pkg::PITCH_MAX)) ? ptsn_pkg::PITCH_MAX
                                                            : l_q[ptsn_pkg::OUT_W-1:0];
        high_edge_q8    <= (h_q > SW'(ptsn_pkg::PITCH_MAX)) ? ptsn_pkg::PITCH_MAX
                                                            : h_q[ptsn_pkg::OUT_W-1:0];
      end
    end
  end

  assign out_valid = v[NS-1];

endmodule

// ===== rtl/pitch_to_semitone_note.sv =====
// Pipeline: 25 log2 stages, then 6 note stages, from input request to result.
// Throughput: one request per cycle while no reference recompute is in progress;
// backpressure stalls each stage independently. Reset: synchronous; reference
// returns to 440 Hz and its log2 is recomputed by a load step and then one step
// per fraction bit, input ready low meanwhile. A configuration write costs the same.
module pitch_to_semitone_note (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ptsn_pkg::REF_W-1:0]          reference_pitch_q8,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ptsn_pkg::PITCH_W-1:0]        pitch_q8,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                no_pitch,
  output logic signed [ptsn_pkg::SEMI_W-1:0]  semitone_number,
  output logic [ptsn_pkg::CLASS_W-1:0]        note_class,
  output logic [ptsn_pkg::OUT_W-1:0]          center_pitch_q8,
  output logic [ptsn_pkg::OUT_W-1:0]          low_edge_q8,
  output logic [ptsn_pkg::OUT_W-1:0]          high_edge_q8
);

  logic                        busy;
  logic [ptsn_pkg::REF_W-1:0]  ref_val;
  logic [ptsn_pkg::LOG_W-1:0]  ref_log;
  logic                        lp_in_ready;
  logic                        lp_valid;
  logic                        lp_ready;
  logic                        lp_no_pitch;
  logic [ptsn_pkg::LOG_W-1:0]  lp_log;

  ptsn_ref_log u_ref_log (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .reference_pitch_q8 (reference_pitch_q8),
    .busy               (busy),
    .ref_val            (ref_val),
    .ref_log            (ref_log)
  );

  assign in_ready = lp_in_ready && !busy;

  ptsn_log_pipe u_log_pipe (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid && !busy),
    .in_ready     (lp_in_ready),
    .pitch_q8     (pitch_q8),
    .out_valid    (lp_valid),
    .out_ready    (lp_ready),
    .out_no_pitch (lp_no_pitch),
    .out_log      (lp_log)
  );

  ptsn_note_pipe u_note_pipe (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (lp_valid),
    .in_ready        (lp_ready),
    .in_no_pitch     (lp_no_pitch),
    .pitch_log       (lp_log),
    .ref_log         (ref_log),
    .ref_val         (ref_val),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .no_pitch        (no_pitch),
    .semitone_number (semitone_number),
    .note_class      (note_class),
    .center_pitch_q8 (center_pitch_q8),
    .low_edge_q8     (low_edge_q8),
    .high_edge_q8    (high_edge_q8)
  );

endmodule

// ===== test/tb.sv =====
module tb;

  localparam int LIMIT_CYCLES = 400000;
  localparam int TAIL_CYCLES  = 64;

  typedef struct packed {
    logic                               no_pitch;
    logic signed [ptsn_pkg::SEMI_W-1:0] semitone;
    logic [ptsn_pkg::CLASS_W-1:0]       note_class;
    logic [ptsn_pkg::OUT_W-1:0]         center;
    logic [ptsn_pkg::OUT_W-1:0]         low_edge;
    logic [ptsn_pkg::OUT_W-1:0]         high_edge;
  } note_t;

  typedef struct {
    logic [ptsn_pkg::PITCH_W-1:0] pitch;
    bit                           typed;
    note_t                        want;
  } pitch_row_t;

  localparam longint unsigned RATIO_Q24 [12] = '{
    16777216, 17774841, 18831788, 19951585, 21137968, 22394897,
    23726566, 25137421, 26632170, 28215802, 29893600, 31671166
  };

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [ptsn_pkg::REF_W-1:0]         reference_pitch_q8 = ptsn_pkg::REF_RESET;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [ptsn_pkg::PITCH_W-1:0]       pitch_q8 = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic                               no_pitch;
  logic signed [ptsn_pkg::SEMI_W-1:0] semitone_number;
  logic [ptsn_pkg::CLASS_W-1:0]       note_class;
  logic [ptsn_pkg::OUT_W-1:0]         center_pitch_q8;
  logic [ptsn_pkg::OUT_W-1:0]         low_edge_q8;
  logic [ptsn_pkg::OUT_W-1:0]         high_edge_q8;

  pitch_to_semitone_note uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .reference_pitch_q8(reference_pitch_q8),
    .in_valid(in_valid), .in_ready(in_ready), .pitch_q8(pitch_q8),
    .out_valid(out_valid), .out_ready(out_ready),
    .no_pitch(no_pitch), .semitone_number(semitone_number), .note_class(note_class),
    .center_pitch_q8(center_pitch_q8), .low_edge_q8(low_edge_q8),
    .high_edge_q8(high_edge_q8)
  );

  always #6 clk = ~clk;

  logic [ptsn_pkg::REF_W-1:0] ref_now = ptsn_pkg::REF_RESET;
  note_t            pending_notes[$];
  int               errors = 0;
  int               mismatches = 0;
  int               cycles = 0;
  int               tx_idle = 0;
  int               rx_idle = 0;

  function automatic longint log2_q24(input longint unsigned v);
    int              e;
    longint unsigned m;
    longint          acc;
    e = 0;
    for (int i = 0; i < 32; i++) if (v[i]) e = i;
    m = (v << (31 - e)) & 64'hFFFF_FFFF;
    acc = longint'(e) << 24;
    for (int i = 23; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        acc += longint'(1) << i;
      end
    end
    return acc;
  endfunction

  function automatic longint floor12(input longint n);
    return n >= 0 ? n / 12 : -((-n + 11) / 12);
  endfunction

  function automatic longint unsigned note_hz_wide(input longint unsigned r, input longint n);
    longint          q, sh, nc;
    longint unsigned x;
    nc = n < -240 ? -240 : (n > 300 ? 300 : n);
    q  = floor12(nc);
    x  = r * RATIO_Q24[nc - 12 * q];
    sh = 16 - q;
    return sh >= 0 ? x >> sh : x << (-sh);
  endfunction

  function automatic logic [ptsn_pkg::OUT_W-1:0] clip_hz(input longint unsigned v);
    return v > ptsn_pkg::PITCH_MAX ? ptsn_pkg::PITCH_MAX : v[ptsn_pkg::OUT_W-1:0];
  endfunction

  function automatic note_t nearest_note(input logic [ptsn_pkg::PITCH_W-1:0] p,
                                         input logic [ptsn_pkg::REF_W-1:0] r);
    note_t           res;
    longint unsigned rr, hp, hc, hn;
    longint          t, n, s, c;
    res = '0;
    if (p < (1 << ptsn_pkg::FRAC_BITS)) begin
      res.no_pitch = 1'b1;
      return res;
    end
    rr = (r == 0) ? 1 : r;
    t = 12 * (log2_q24(p) - log2_q24(rr));
    if (t < 0) n = -((-t + (longint'(1) << 23)) >>> 24);
    else       n = (t + (longint'(1) << 23)) >>> 24;
    s = n < -128 ? -128 : (n > 127 ? 127 : n);
    c = n - 12 * floor12(n);
    hp = note_hz_wide(rr, n - 1);
    hc = note_hz_wide(rr, n);
    hn = note_hz_wide(rr, n + 1);
    res.semitone   = s[ptsn_pkg::SEMI_W-1:0];
    res.note_class = c[ptsn_pkg::CLASS_W-1:0];
    res.center     = clip_hz((hc + 128) >> 8);
    res.low_edge   = clip_hz((hp + hc + 256) >> 9);
    res.high_edge  = clip_hz((hc + hn + 256) >> 9);
    return res;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("[pitch_to_semitone_note] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    note_t got, want;
    out_ready <= ($urandom_range(99) >= rx_idle);
    if (!rst && out_valid && out_ready) begin
      got = '{no_pitch, semitone_number, note_class, center_pitch_q8,
              low_edge_q8, high_edge_q8};
      if (pending_notes.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result %p", got);
      end else begin
        want = pending_notes.pop_front();
        if (got.no_pitch !== want.no_pitch || got.semitone !== want.semitone ||
            got.note_class !== want.note_class || got.center !== want.center ||
            got.low_edge !== want.low_edge || got.high_edge !== want.high_edge) begin
          errors++;
          if (mismatches++ < 10) $display("mismatch exp %p got %p", want, got);
        end
      end
    end
  end

  task automatic send_pitch(input logic [ptsn_pkg::PITCH_W-1:0] p, input bit typed,
                            input note_t want);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pitch_q8 <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_notes.push_back(typed ? want : nearest_note(p, ref_now));
  endtask

  task automatic send_random(input int count);
    int                           kind, e;
    logic [ptsn_pkg::PITCH_W-1:0] p;
    logic [ptsn_pkg::PITCH_W-1:0] top;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      if (kind < 8) p = ptsn_pkg::PITCH_W'($urandom_range(255));
      else if (kind < 25) p = ptsn_pkg::PITCH_W'($urandom);
      else begin
        e   = $urandom_range(8, ptsn_pkg::PITCH_W - 1);
        top = ptsn_pkg::PITCH_W'(1) << e;
        p   = top | (ptsn_pkg::PITCH_W'($urandom) & (top - 1'b1));
      end
      send_pitch(p, 1'b0, '0);
    end
  endtask

  task automatic write_reference(input logic [ptsn_pkg::REF_W-1:0] r);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_notes.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    reference_pitch_q8 <= r;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    ref_now = r;
  endtask

  pitch_row_t directed[] = '{
    '{22'd0,       1'b1, note_t'{1'b1, 8'sd0, 4'd0, 23'd0, 23'd0, 23'd0}},
    '{22'd1,       1'b1, note_t'{1'b1, 8'sd0, 4'd0, 23'd0, 23'd0, 23'd0}},
    '{22'd255,     1'b1, note_t'{1'b1, 8'sd0, 4'd0, 23'd0, 23'd0, 23'd0}},
    '{22'd256,     1'b0, '0},
    '{22'd257,     1'b0, '0},
    '{22'd112640,  1'b0, '0},
    '{22'd112641,  1'b0, '0},
    '{22'd225280,  1'b0, '0},
    '{22'd56320,   1'b0, '0},
    '{22'd119338,  1'b0, '0},
    '{22'd116000,  1'b0, '0},
    '{22'd109400,  1'b0, '0},
    '{22'd2097152, 1'b0, '0},
    '{22'h2AAAAA,  1'b0, '0},
    '{22'h155555,  1'b0, '0},
    '{22'd4194302, 1'b0, '0},
    '{22'd4194303, 1'b0, '0}
  };

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    tx_idle = 8;
    rx_idle = 88;
    foreach (directed[i]) send_pitch(directed[i].pitch, directed[i].typed, directed[i].want);

    // zero reference acts as one LSB; top pitches saturate
    write_reference('0);
    send_pitch(22'd256, 1'b0, '0);
    send_pitch(22'd4194303, 1'b0, '0);
    send_pitch(22'd65536, 1'b0, '0);
    write_reference('1);
    send_pitch(22'd256, 1'b0, '0);
    send_pitch(22'd4194303, 1'b0, '0);
    send_pitch(22'd131071, 1'b0, '0);

    write_reference(17'd102400);
    send_random(250);

    tx_idle = 88;
    rx_idle = 8;
    write_reference(17'd122880);
    send_random(250);

    tx_idle = 0;
    rx_idle = 0;
    write_reference(ptsn_pkg::REF_W'($urandom_range(102400, 122880)));
    send_random(125);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_notes.size() != 0) @(posedge clk);
    send_random(125);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_notes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0 && pending_notes.size() == 0) begin
      $display("[pitch_to_semitone_note] OK");
    end else begin
      $display("[pitch_to_semitone_note] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ptsn_pkg.sv
rtl/ptsn_ref_log.sv
rtl/ptsn_log_pipe.sv
rtl/ptsn_note_pipe.sv
rtl/pitch_to_semitone_note.sv
test/tb.sv
